/* design/htud_pkg.sv */
// ----------------------------------------------------------------------------
// Huffman tree unpack/decode package
// Shared sizes, codes and the command/status bundles between control and
// datapath.
// ----------------------------------------------------------------------------
package htud_pkg;

    // return stack
    localparam int StackDepth = 32;
    localparam int StackAw    = $clog2(StackDepth);
    localparam int LevelW     = $clog2(StackDepth + 1);

    // node table: bit 9 leaf flag, bits 7..0 symbol, or bits 8..0 right link
    localparam int NodeCount = 511;
    localparam int NodeIdxW  = 9;
    localparam int NodeW     = 10;
    localparam int LeafBit   = 9;
    localparam logic [NodeIdxW-1:0] NodeLimit = NodeIdxW'(NodeCount);

    // config register map (byte lanes below bit 2 ignored)
    localparam int  PaddrW       = 3;
    localparam logic RegByteCount = 1'b0;
    localparam logic RegStride    = 1'b1;

    // result status codes
    localparam logic [1:0] StatusOk      = 2'd0;
    localparam logic [1:0] StatusTooDeep = 2'd1;
    localparam logic [1:0] StatusTooMany = 2'd2;

    typedef enum logic [1:0] {
        EM_BYTE,
        EM_FILL,
        EM_DEEP,
        EM_NODES
    } t_emit;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ZERO,
        CUR_INC,
        CUR_NEXT_FREE,
        CUR_NODE,
        CUR_STACK
    } t_cur_sel;

    typedef enum logic [1:0] {
        NW_ZERO,
        NW_LEAF,
        NW_LINK
    } t_node_wsel;

    typedef struct packed {
        logic       clear;
        logic       stream_bit;
        logic       sym_begin;
        logic       sym_shift;
        t_cur_sel   cur_sel;
        logic       node_rd;
        logic       node_wr;
        t_node_wsel node_wsel;
        logic       push;
        logic       stack_rd;
        logic       level_dec;
        logic       nf_inc;
        logic       emit;
        t_emit      emit_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic stack_empty;
        logic stack_full;
        logic nodes_full;
        logic single_leaf;
        logic sym_last;
        logic node_zero;
        logic node_leaf;
        logic last_byte;
    } t_dp_sts;

endpackage

/* design/htud_if.sv */
// ----------------------------------------------------------------------------
// Huffman tree unpack/decode channel interfaces
// Stream-bit input channel and decoded-result output channel, valid/ready.
// ----------------------------------------------------------------------------
interface htud_bit_if;
    logic valid;
    logic ready;
    logic func;
    logic stream_bit;

    modport source (output valid, output func, output stream_bit, input ready);
    modport sink   (input valid, input func, input stream_bit, output ready);
endinterface

interface htud_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  symbol;
    logic [23:0] write_offset;
    logic        fill_all;
    logic        last;
    logic [1:0]  status;

    modport source (output valid, output symbol, output write_offset, output fill_all,
                    output last, output status, input ready);
    modport sink   (input valid, input symbol, input write_offset, input fill_all,
                    input last, input status, output ready);
endinterface

/* design/huffman_tree_unpack_decode_top.sv */
// ----------------------------------------------------------------------------
// Huffman tree unpack/decode top level
// Rebuilds a preorder-coded Huffman tree from a bit stream, then decodes bytes.
// Timing: start, branch and symbol bits pass through WAIT and EXEC; a finished leaf
//   then climbs the stack through POP, POP_NODE and POP_CHK per level, ending in POP when empty.
// Decode: a 0 bit passes EXEC and DEC_CHK, a 1 bit adds DEC_RIGHT (two dependent
//   table reads); any result then waits in EMIT while the output register is stalled.
// Reset (i_rst_n, synchronous): idle awaiting start, byte_count and stride 1;
//   node table and return stack are not cleared.
// ----------------------------------------------------------------------------
module huffman_tree_unpack_decode_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    htud_bit_if.sink                      i_bit_ch,
    htud_res_if.source                    o_res_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [htud_pkg::PaddrW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [15:0]       r_byte_count;
    logic [7:0]        r_stride;
    logic              cfg_wr;
    htud_pkg::t_dp_cmd cmd;
    htud_pkg::t_dp_sts sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 16'd1;
            r_stride     <= 8'd1;
        end else if (cfg_wr) begin
            case (paddr[2])
                htud_pkg::RegByteCount: r_byte_count <= pwdata[15:0];
                htud_pkg::RegStride:    r_stride     <= pwdata[7:0];
                default:                r_stride     <= r_stride;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            htud_pkg::RegByteCount: prdata = {16'd0, r_byte_count};
            htud_pkg::RegStride:    prdata = {24'd0, r_stride};
            default:                prdata = '0;
        endcase
    end

    htud_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_bit_ch.valid),
        .i_func  (i_bit_ch.func),
        .i_bit   (i_bit_ch.stream_bit),
        .o_ready (i_bit_ch.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    htud_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_byte_count   (r_byte_count),
        .i_stride       (r_stride),
        .i_out_ready    (o_res_ch.ready),
        .o_sts          (sts),
        .o_out_valid    (o_res_ch.valid),
        .o_symbol       (o_res_ch.symbol),
        .o_write_offset (o_res_ch.write_offset),
        .o_fill_all     (o_res_ch.fill_all),
        .o_last         (o_res_ch.last),
        .o_status       (o_res_ch.status)
    );

    // a result is only loaded when the output register is free or draining
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded over an untaken result");

    // one bit in flight at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_bit_ch.valid && i_bit_ch.ready) |=> !i_bit_ch.ready)
        else $error("input taken while previous bit still in work");

    a_err_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_ch.valid && (o_res_ch.status != htud_pkg::StatusOk))
        |-> (o_res_ch.last && !o_res_ch.fill_all))
        else $error("error result not marked last");

    a_fill_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_ch.valid && o_res_ch.fill_all)
        |-> (o_res_ch.last && (o_res_ch.write_offset == 24'd0)))
        else $error("fill-all result malformed");

endmodule

/* design/htud_ctrl.sv */
// ----------------------------------------------------------------------------
// Huffman tree unpack/decode controller
// Tracks the block phase and sequences table/stack accesses for each bit.
// ----------------------------------------------------------------------------
module htud_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_func,
    input  logic              i_bit,
    output logic              o_ready,
    input  htud_pkg::t_dp_sts i_sts,
    output htud_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_KIND,
        PH_SYM,
        PH_DECODE,
        PH_STOP
    } t_phase;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_EXEC,
        ST_POP,
        ST_POP_NODE,
        ST_POP_CHK,
        ST_DEC_RIGHT,
        ST_DEC_CHK,
        ST_EMIT
    } t_state;

    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    htud_pkg::t_emit r_emit_kind, n_emit_kind;
    logic            r_func, r_bit;

    assign o_ready = (r_state == ST_WAIT);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_emit_kind = r_emit_kind;
        o_cmd            = '0;
        o_cmd.stream_bit = r_bit;
        o_cmd.cur_sel    = htud_pkg::CUR_HOLD;
        o_cmd.node_wsel  = htud_pkg::NW_ZERO;
        o_cmd.emit_kind  = r_emit_kind;

        case (r_state)
            ST_WAIT: begin
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end

            ST_EXEC: begin
                n_state = ST_WAIT;
                if (r_func) begin
                    o_cmd.clear   = 1'b1;
                    o_cmd.cur_sel = htud_pkg::CUR_ZERO;
                    n_phase       = PH_KIND;
                end else begin
                    case (r_phase)
                        PH_KIND: begin
                            if (r_bit) begin
                                o_cmd.sym_begin = 1'b1;
                                n_phase         = PH_SYM;
                            end else if (i_sts.stack_full) begin
                                n_emit_kind = htud_pkg::EM_DEEP;
                                n_phase     = PH_STOP;
                                n_state     = ST_EMIT;
                            end else if (i_sts.nodes_full) begin
                                n_emit_kind = htud_pkg::EM_NODES;
                                n_phase     = PH_STOP;
                                n_state     = ST_EMIT;
                            end else begin
                                o_cmd.push      = 1'b1;
                                o_cmd.node_wr   = 1'b1;
                                o_cmd.node_wsel = htud_pkg::NW_ZERO;
                                o_cmd.cur_sel   = htud_pkg::CUR_NEXT_FREE;
                                o_cmd.nf_inc    = 1'b1;
                            end
                        end
                        PH_SYM: begin
                            o_cmd.sym_shift = 1'b1;
                            if (i_sts.sym_last) begin
                                o_cmd.node_wr   = 1'b1;
                                o_cmd.node_wsel = htud_pkg::NW_LEAF;
                                n_state         = ST_POP;
                            end
                        end
                        PH_DECODE: begin
                            o_cmd.node_rd = 1'b1;
                            if (r_bit) begin
                                // fetch the current branch for its right link
                                n_state = ST_DEC_RIGHT;
                            end else begin
                                o_cmd.cur_sel = htud_pkg::CUR_INC;
                                n_state       = ST_DEC_CHK;
                            end
                        end
                        default: begin
                            n_state = ST_WAIT;
                        end
                    endcase
                end
            end

            // climb the return stack looking for a branch whose right side is open
            ST_POP: begin
                if (i_sts.stack_empty) begin
                    o_cmd.cur_sel = htud_pkg::CUR_ZERO;
                    if (i_sts.single_leaf) begin
                        n_emit_kind = htud_pkg::EM_FILL;
                        n_phase     = PH_STOP;
                        n_state     = ST_EMIT;
                    end else begin
                        n_phase = PH_DECODE;
                        n_state = ST_WAIT;
                    end
                end else begin
                    o_cmd.stack_rd = 1'b1;
                    n_state        = ST_POP_NODE;
                end
            end

            ST_POP_NODE: begin
                o_cmd.cur_sel = htud_pkg::CUR_STACK;
                o_cmd.node_rd = 1'b1;
                n_state       = ST_POP_CHK;
            end

            ST_POP_CHK: begin
                if (i_sts.node_zero) begin
                    if (i_sts.nodes_full) begin
                        n_emit_kind = htud_pkg::EM_NODES;
                        n_phase     = PH_STOP;
                        n_state     = ST_EMIT;
                    end else begin
                        o_cmd.node_wr   = 1'b1;
                        o_cmd.node_wsel = htud_pkg::NW_LINK;
                        o_cmd.cur_sel   = htud_pkg::CUR_NEXT_FREE;
                        o_cmd.nf_inc    = 1'b1;
                        n_phase         = PH_KIND;
                        n_state         = ST_WAIT;
                    end
                end else begin
                    o_cmd.level_dec = 1'b1;
                    n_state         = ST_POP;
                end
            end

            ST_DEC_RIGHT: begin
                o_cmd.cur_sel = htud_pkg::CUR_NODE;
                o_cmd.node_rd = 1'b1;
                n_state       = ST_DEC_CHK;
            end

            ST_DEC_CHK: begin
                if (i_sts.node_leaf) begin
                    n_emit_kind = htud_pkg::EM_BYTE;
                    n_state     = ST_EMIT;
                end else begin
                    n_state = ST_WAIT;
                end
            end

            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_WAIT;
                    if (r_emit_kind == htud_pkg::EM_BYTE) begin
                        o_cmd.cur_sel = htud_pkg::CUR_ZERO;
                        if (i_sts.last_byte) begin
                            n_phase = PH_STOP;
                        end
                    end
                end
            end

            default: begin
                n_state = ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WAIT;
            r_phase     <= PH_IDLE;
            r_emit_kind <= htud_pkg::EM_BYTE;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_emit_kind <= n_emit_kind;
        end
        if (o_ready && i_valid) begin
            r_func <= i_func;
            r_bit  <= i_bit;
        end
    end

endmodule

/* design/htud_dp.sv */
// ----------------------------------------------------------------------------
// Huffman tree unpack/decode datapath
// Node table, return stack, walk pointers, byte counters and result register.
// ----------------------------------------------------------------------------
module htud_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  htud_pkg::t_dp_cmd i_cmd,
    input  logic [15:0]       i_byte_count,
    input  logic [7:0]        i_stride,
    input  logic              i_out_ready,
    output htud_pkg::t_dp_sts o_sts,
    output logic              o_out_valid,
    output logic [7:0]        o_symbol,
    output logic [23:0]       o_write_offset,
    output logic              o_fill_all,
    output logic              o_last,
    output logic [1:0]        o_status
);

    logic [htud_pkg::NodeW-1:0]    r_node_mem [htud_pkg::NodeCount];
    logic [htud_pkg::NodeIdxW-1:0] r_stack_mem [htud_pkg::StackDepth];

    logic [htud_pkg::NodeIdxW-1:0] r_current, n_current;
    logic [htud_pkg::NodeIdxW-1:0] r_next_free;
    logic [htud_pkg::LevelW-1:0]   r_level;
    logic [7:0]                    r_sym;
    logic [2:0]                    r_bits;
    logic [15:0]                   r_bytes_done;
    logic [23:0]                   r_offset;

    logic [htud_pkg::NodeW-1:0]    r_node_rd;
    logic                          r_node_oob;
    logic [htud_pkg::NodeIdxW-1:0] r_stack_rd;

    logic [htud_pkg::NodeW-1:0]    node_val;
    logic [htud_pkg::NodeW-1:0]    node_wdata;
    logic [7:0]                    sym_new;
    logic [htud_pkg::LevelW-1:0]   level_m1;
    logic [16:0]                   done_inc;

    // index 511 lies past the table and reads as zero
    assign node_val = r_node_oob ? '0 : r_node_rd;
    assign sym_new  = r_sym | (8'(i_cmd.stream_bit) << r_bits);
    assign level_m1 = r_level - htud_pkg::LevelW'(1);
    assign done_inc = {1'b0, r_bytes_done} + 17'd1;

    always_comb begin
        case (i_cmd.cur_sel)
            htud_pkg::CUR_HOLD:      n_current = r_current;
            htud_pkg::CUR_ZERO:      n_current = '0;
            htud_pkg::CUR_INC:       n_current = r_current + htud_pkg::NodeIdxW'(1);
            htud_pkg::CUR_NEXT_FREE: n_current = r_next_free;
            htud_pkg::CUR_NODE:      n_current = node_val[htud_pkg::NodeIdxW-1:0];
            htud_pkg::CUR_STACK:     n_current = r_stack_rd;
            default:                 n_current = r_current;
        endcase
    end

    always_comb begin
        case (i_cmd.node_wsel)
            htud_pkg::NW_ZERO: node_wdata = '0;
            htud_pkg::NW_LEAF: node_wdata = {2'b10, sym_new};
            htud_pkg::NW_LINK: node_wdata = {1'b0, r_next_free};
            default:           node_wdata = '0;
        endcase
    end

    assign o_sts.out_free    = !o_out_valid || i_out_ready;
    assign o_sts.stack_empty = (r_level == '0);
    assign o_sts.stack_full  = (r_level >= htud_pkg::LevelW'(htud_pkg::StackDepth));
    assign o_sts.nodes_full  = (r_next_free == htud_pkg::NodeLimit);
    assign o_sts.single_leaf = (r_next_free == htud_pkg::NodeIdxW'(1));
    assign o_sts.sym_last    = (r_bits == 3'd7);
    assign o_sts.node_zero   = (node_val == '0);
    assign o_sts.node_leaf   = node_val[htud_pkg::LeafBit];
    assign o_sts.last_byte   = (done_inc >= {1'b0, i_byte_count});

    // node table: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.node_wr && (r_current != htud_pkg::NodeLimit)) begin
            r_node_mem[r_current] <= node_wdata;
        end
        if (i_cmd.node_rd) begin
            r_node_rd  <= r_node_mem[n_current];
            r_node_oob <= (n_current == htud_pkg::NodeLimit);
        end
    end

    // return stack of open branches
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack_mem[r_level[htud_pkg::StackAw-1:0]] <= r_current;
        end
        if (i_cmd.stack_rd) begin
            r_stack_rd <= r_stack_mem[level_m1[htud_pkg::StackAw-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current    <= '0;
            r_next_free  <= htud_pkg::NodeIdxW'(1);
            r_level      <= '0;
            r_sym        <= '0;
            r_bits       <= '0;
            r_bytes_done <= '0;
            r_offset     <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            r_current <= n_current;
            if (i_cmd.clear) begin
                r_next_free  <= htud_pkg::NodeIdxW'(1);
                r_level      <= '0;
                r_sym        <= '0;
                r_bits       <= '0;
                r_bytes_done <= '0;
                r_offset     <= '0;
            end else begin
                if (i_cmd.nf_inc) begin
                    r_next_free <= r_next_free + htud_pkg::NodeIdxW'(1);
                end
                if (i_cmd.push) begin
                    r_level <= r_level + htud_pkg::LevelW'(1);
                end else if (i_cmd.level_dec) begin
                    r_level <= level_m1;
                end
                if (i_cmd.sym_begin) begin
                    r_sym  <= '0;
                    r_bits <= '0;
                end else if (i_cmd.sym_shift) begin
                    r_sym  <= sym_new;
                    r_bits <= r_bits + 3'd1;
                end
                if (i_cmd.emit && (i_cmd.emit_kind == htud_pkg::EM_BYTE)) begin
                    r_bytes_done <= done_inc[15:0];
                    r_offset     <= r_offset + {16'd0, i_stride};
                end
            end
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            case (i_cmd.emit_kind)
                htud_pkg::EM_BYTE: begin
                    o_symbol       <= node_val[7:0];
                    o_write_offset <= r_offset;
                    o_fill_all     <= 1'b0;
                    o_last         <= o_sts.last_byte;
                    o_status       <= htud_pkg::StatusOk;
                end
                htud_pkg::EM_FILL: begin
                    o_symbol       <= r_sym;
                    o_write_offset <= '0;
                    o_fill_all     <= 1'b1;
                    o_last         <= 1'b1;
                    o_status       <= htud_pkg::StatusOk;
                end
                htud_pkg::EM_DEEP: begin
                    o_symbol       <= '0;
                    o_write_offset <= '0;
                    o_fill_all     <= 1'b0;
                    o_last         <= 1'b1;
                    o_status       <= htud_pkg::StatusTooDeep;
                end
                default: begin
                    o_symbol       <= '0;
                    o_write_offset <= '0;
                    o_fill_all     <= 1'b0;
                    o_last         <= 1'b1;
                    o_status       <= htud_pkg::StatusTooMany;
                end
            endcase
        end
    end

endmodule
